>>> rtl/qwid_pkg.sv
// Shared types and constants for the quiet window interactive detector.
package qwid_pkg;

    localparam int unsigned FIELD_TIME_W = 63;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned WINDOW_W     = 48;
    localparam int unsigned TOL_W        = 8;
    localparam int unsigned CFG_INDEX_W  = 1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 48'd5000000000;
    localparam logic [TOL_W-1:0]    TOL_RESET    = 8'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_START       = 3'd0,
        KIND_TASK_START  = 3'd1,
        KIND_TASK_END    = 3'd2,
        KIND_REQ_START   = 3'd3,
        KIND_REQ_END     = 3'd4,
        KIND_NAV_END     = 3'd5
    } kind_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH     = 1'd0,
        CFG_REQUEST_TOLERANCE = 1'd1
    } cfg_index_e;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [FIELD_TIME_W-1:0] event_time;
    } in_t;

    typedef struct packed {
        logic                    reached;
        logic [FIELD_TIME_W-1:0] interactive_time;
    } out_t;

    // Decoded event class; navigation end and unused kinds leave all flags low.
    typedef struct packed {
        logic is_start;
        logic is_task_start;
        logic is_task_end;
        logic is_req_start;
        logic is_req_end;
    } ev_class_t;

endpackage

>>> rtl/quiet_window_interactive_detector.sv
// Quiet window interactive detector: top level with configuration registers.
// Takes one time-ordered event per cycle unless stalled and returns one result
// per event, in order. An event passes the front-end decode register, a
// two-entry queue and the back end, which updates the quiet window state and
// loads the result register. Back-to-back events give one result per cycle when
// neither side stalls; the single back-end state update per event (two wide
// elapsed-time compares and the request counter) sets that rate. Either side
// may stall without losing or repeating items.
// Configuration writes are always taken (cfg_ready stays high) and are meant
// only while no event is in flight. Index 0 sets window_length (48 bits),
// index 1 sets request_tolerance (low 8 bits of cfg_data).
module quiet_window_interactive_detector #(
    parameter int unsigned TIME_BITS  = 63,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  qwid_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output qwid_pkg::out_t                    out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qwid_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [qwid_pkg::WINDOW_W-1:0]     cfg_data
);
    import qwid_pkg::*;

    localparam int unsigned QW = $bits(ev_class_t) + TIME_BITS;

    logic [WINDOW_W-1:0]  window_length_reg;
    logic [TOL_W-1:0]     request_tolerance_reg;

    logic                 fe_valid;
    logic                 fe_ready;
    ev_class_t            fe_class;
    logic [TIME_BITS-1:0] fe_time;

    logic                 q_valid;
    logic                 q_ready;
    logic [QW-1:0]        q_data;
    ev_class_t            q_class;
    logic [TIME_BITS-1:0] q_time;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg     <= WINDOW_RESET;
            request_tolerance_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_e'(cfg_index))
                CFG_WINDOW_LENGTH:     window_length_reg     <= cfg_data;
                CFG_REQUEST_TOLERANCE: request_tolerance_reg <= cfg_data[TOL_W-1:0];
                default:               window_length_reg     <= window_length_reg;
            endcase
        end
    end

    qwid_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .ev_valid (fe_valid),
        .ev_ready (fe_ready),
        .ev_class (fe_class),
        .ev_time  (fe_time)
    );

    qwid_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  ({fe_class, fe_time}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_class = q_data[QW-1:TIME_BITS];
    assign q_time  = q_data[TIME_BITS-1:0];

    qwid_back #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .ev_valid          (q_valid),
        .ev_ready          (q_ready),
        .ev_class          (q_class),
        .ev_time           (q_time),
        .window_length     (window_length_reg),
        .request_tolerance (request_tolerance_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_data          (out_data)
    );

endmodule

>>> rtl/qwid_front.sv
// Front end: accepts events, decodes the kind and holds them in an input register.
module qwid_front #(
    parameter int unsigned TIME_BITS = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qwid_pkg::in_t        in_data,
    output logic                 ev_valid,
    input  logic                 ev_ready,
    output qwid_pkg::ev_class_t  ev_class,
    output logic [TIME_BITS-1:0] ev_time
);
    import qwid_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    ev_class_t            class_reg;
    ev_class_t            class_next;
    logic [TIME_BITS-1:0] time_reg;
    logic                 load;

    assign in_ready = !valid_reg || ev_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        class_next = '0;
        unique case (kind_e'(in_data.kind))
            KIND_START:      class_next.is_start      = 1'b1;
            KIND_TASK_START: class_next.is_task_start = 1'b1;
            KIND_TASK_END:   class_next.is_task_end   = 1'b1;
            KIND_REQ_START:  class_next.is_req_start  = 1'b1;
            KIND_REQ_END:    class_next.is_req_end    = 1'b1;
            default:         class_next               = '0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ev_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Drop the upper time bits beyond the configured width.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= class_next;
            time_reg  <= in_data.event_time[TIME_BITS-1:0];
        end
    end

    assign ev_valid = valid_reg;
    assign ev_class = class_reg;
    assign ev_time  = time_reg;

endmodule

>>> rtl/qwid_queue.sv
// Two-entry event queue between the front end and the back end.
module qwid_queue #(
    parameter int unsigned WIDTH = 68
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import qwid_pkg::*;

    localparam int unsigned DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/qwid_back.sv
// Back end: quiet window state, quiescence test and the result register.
module qwid_back #(
    parameter int unsigned TIME_BITS  = 63,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ev_valid,
    output logic                                  ev_ready,
    input  qwid_pkg::ev_class_t                   ev_class,
    input  logic [TIME_BITS-1:0]                  ev_time,
    input  logic [qwid_pkg::WINDOW_W-1:0]         window_length,
    input  logic [qwid_pkg::TOL_W-1:0]            request_tolerance,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output qwid_pkg::out_t                        out_data
);
    import qwid_pkg::*;

    // Difference width: room for both operands plus a sign bit.
    localparam int unsigned DW = ((TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W) + 1;
    // Counter compare width: one bit of headroom over the counter and the tolerance.
    localparam int unsigned CW = ((COUNT_BITS + 1 > TOL_W + 1) ? COUNT_BITS + 1 : TOL_W + 1);

    logic [TIME_BITS-1:0]  main_start_reg, main_start_next;
    logic                  main_valid_reg, main_valid_next;
    logic [TIME_BITS-1:0]  net_start_reg, net_start_next;
    logic                  net_valid_reg, net_valid_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  found_reg, found_next;
    logic [TIME_BITS-1:0]  found_time_reg, found_time_next;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_data_reg, out_data_next;

    logic                  take;
    logic [DW-1:0]         main_diff;
    logic [DW-1:0]         net_diff;
    logic                  main_long;
    logic                  net_long;
    logic [CW-1:0]         count_inc;
    logic [COUNT_BITS-1:0] count_dec;

    assign ev_ready = !out_valid_reg || out_ready;
    assign take     = ev_valid && ev_ready;

    // Signed elapsed time per window; a negative difference never passes.
    assign main_diff = DW'(ev_time) - DW'(main_start_reg);
    assign net_diff  = DW'(ev_time) - DW'(net_start_reg);
    assign main_long = !main_diff[DW-1] && (main_diff > DW'(window_length));
    assign net_long  = !net_diff[DW-1] && (net_diff > DW'(window_length));

    assign count_inc = CW'(count_reg) + CW'(1);
    assign count_dec = count_reg - COUNT_BITS'(1);

    always_comb
    begin
        main_start_next = main_start_reg;
        main_valid_next = main_valid_reg;
        net_start_next  = net_start_reg;
        net_valid_next  = net_valid_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        found_time_next = found_time_reg;

        if (ev_class.is_start)
        begin
            main_start_next = ev_time;
            main_valid_next = 1'b1;
            net_start_next  = ev_time;
            net_valid_next  = 1'b1;
            count_next      = '0;
            found_next      = 1'b0;
            found_time_next = '0;
        end
        else if (!found_reg)
        begin
            if (main_valid_reg && net_valid_reg && main_long && net_long)
            begin
                found_next      = 1'b1;
                found_time_next = main_start_reg;
            end
            else if (ev_class.is_task_start)
            begin
                main_valid_next = 1'b0;
            end
            else if (ev_class.is_task_end)
            begin
                main_start_next = ev_time;
                main_valid_next = 1'b1;
            end
            else if (ev_class.is_req_start)
            begin
                if (count_inc > CW'(request_tolerance))
                begin
                    net_valid_next = 1'b0;
                end
                // Hold the counter at its top value.
                if (count_reg != {COUNT_BITS{1'b1}})
                begin
                    count_next = count_inc[COUNT_BITS-1:0];
                end
            end
            else if (ev_class.is_req_end)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_dec;
                    if (CW'(count_dec) == CW'(request_tolerance))
                    begin
                        net_start_next = ev_time;
                        net_valid_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take)
        begin
            out_valid_next                 = 1'b1;
            out_data_next.reached          = found_next;
            out_data_next.interactive_time =
                found_next ? FIELD_TIME_W'(found_time_next) : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_start_reg <= '0;
            main_valid_reg <= 1'b0;
            net_start_reg  <= '0;
            net_valid_reg  <= 1'b0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            found_time_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                main_start_reg <= main_start_next;
                main_valid_reg <= main_valid_next;
                net_start_reg  <= net_start_next;
                net_valid_reg  <= net_valid_next;
                count_reg      <= count_next;
                found_reg      <= found_next;
                found_time_reg <= found_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sim/tb_top.sv
// Testbench for the quiet window interactive detector: directed and random event traces.
`timescale 1ns / 100ps

module tb_top;
    import qwid_pkg::*;

    localparam int unsigned COUNT_W = 16;
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
    localparam logic [FIELD_TIME_W-1:0] TIME_MAX = '1;
    localparam int unsigned RANDOM_ITEMS = 650;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WINDOW_W-1:0] cfg_data = '0;

    // Predicted detector state and configuration
    logic [WINDOW_W-1:0] win_len = WINDOW_RESET;
    logic [TOL_W-1:0] req_tol = TOL_RESET;
    logic [FIELD_TIME_W-1:0] main_since = '0;
    logic [FIELD_TIME_W-1:0] net_since = '0;
    logic [FIELD_TIME_W-1:0] latched_time = '0;
    logic main_open = 1'b0;
    logic net_open = 1'b0;
    logic latched = 1'b0;
    logic [COUNT_W-1:0] inflight = '0;

    out_t verdict_q[$];
    int unsigned mismatch_count = 0;
    int unsigned sent_items = 0;
    int unsigned src_gap_max = 0;
    int unsigned sink_gap_max = 0;
    int unsigned sink_hold = 0;

    quiet_window_interactive_detector #(
        .TIME_BITS(FIELD_TIME_W),
        .COUNT_BITS(COUNT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic quiet_long(input logic [FIELD_TIME_W-1:0] now,
                                        input logic [FIELD_TIME_W-1:0] since);
        logic signed [63:0] span;
        span = $signed({1'b0, now}) - $signed({1'b0, since});
        return span > $signed({16'd0, win_len});
    endfunction

    function automatic out_t step_quiet_tracker(input in_t ev);
        logic [COUNT_W:0] bumped;
        out_t res;
        if (ev.kind == KIND_START)
        begin
            main_since = ev.event_time;
            net_since = ev.event_time;
            main_open = 1'b1;
            net_open = 1'b1;
            inflight = '0;
            latched = 1'b0;
            latched_time = '0;
        end
        else if (!latched)
        begin
            if (main_open && net_open && quiet_long(ev.event_time, main_since)
                && quiet_long(ev.event_time, net_since))
            begin
                latched = 1'b1;
                latched_time = main_since;
            end
            else
            begin
                case (ev.kind)
                    KIND_TASK_START: main_open = 1'b0;
                    KIND_TASK_END:
                    begin
                        main_since = ev.event_time;
                        main_open = 1'b1;
                    end
                    KIND_REQ_START:
                    begin
                        bumped = {1'b0, inflight} + 1'b1;
                        if (bumped > {{(COUNT_W + 1 - TOL_W){1'b0}}, req_tol})
                            net_open = 1'b0;
                        // hold the counter at its ceiling
                        inflight = bumped[COUNT_W] ? '1 : bumped[COUNT_W-1:0];
                    end
                    KIND_REQ_END:
                    begin
                        if (inflight != '0)
                        begin
                            inflight = inflight - 1'b1;
                            if (inflight == {{(COUNT_W - TOL_W){1'b0}}, req_tol})
                            begin
                                net_since = ev.event_time;
                                net_open = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        res.reached = latched;
        res.interactive_time = latched ? latched_time : '0;
        return res;
    endfunction

    task automatic send_event(input logic [KIND_W-1:0] kind,
                              input logic [FIELD_TIME_W-1:0] stamp);
        int unsigned gap;
        in_t ev;
        ev.kind = kind;
        ev.event_time = stamp;
        gap = $urandom_range(src_gap_max, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= ev;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        verdict_q.insert(verdict_q.size(), step_quiet_tracker(ev));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back; the tolerance word may carry junk above bit 7.
    task automatic write_config(input logic [WINDOW_W-1:0] length,
                                input logic [WINDOW_W-1:0] tol_word);
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data <= length;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        win_len = length;
        cfg_index <= CFG_REQUEST_TOLERANCE;
        cfg_data <= tol_word;
        do @(posedge clk); while (!cfg_ready);
        req_tol = tol_word[TOL_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // Reset values: nothing can be found before the first start event.
    task automatic check_reset_defaults();
        send_event(KIND_TASK_END, 63'd0);
        send_event(KIND_REQ_START, 63'd1);
        send_event(KIND_REQ_END, 63'd2);
        send_event(KIND_NAV_END, 63'h4000_0000_0000_0000);
        send_event(KIND_START, 63'd10);
        send_event(KIND_NAV_END, 63'd5_000_000_010);
        send_event(KIND_NAV_END, 63'd5_000_000_011);
        send_event(KIND_TASK_START, 63'd6_000_000_000);
        wait_for_results();
    endtask

    task automatic check_event_kinds();
        write_config(48'd100, {40'hA5_5A0F_F000, 8'd1});
        send_event(KIND_START, 63'd1000);
        send_event(KIND_REQ_START, 63'd1000);
        send_event(KIND_REQ_START, 63'd1010);
        send_event(KIND_TASK_START, 63'd1020);
        send_event(KIND_NAV_END, 63'd2000);
        send_event(KIND_TASK_END, 63'd2000);
        send_event(KIND_REQ_END, 63'd2050);
        send_event(KIND_REQ_END, 63'd2060);
        send_event(KIND_REQ_END, 63'd2070);
        send_event(KIND_SPARE_6, 63'd2150);
        send_event(KIND_SPARE_7, 63'd2151);
        send_event(KIND_TASK_START, 63'd5000);
        send_event(KIND_START, 63'd100);
        wait_for_results();
        // zero window: a strictly later time is enough, an earlier one never is
        write_config(48'd0, 48'd0);
        send_event(KIND_START, 63'd100);
        send_event(KIND_NAV_END, 63'd50);
        send_event(KIND_NAV_END, 63'd100);
        send_event(KIND_NAV_END, 63'd101);
        wait_for_results();
    endtask

    task automatic check_field_extremes();
        write_config('1, '1);
        send_event(KIND_START, TIME_MAX - (63'd1 << WINDOW_W));
        send_event(KIND_NAV_END, TIME_MAX);
        send_event(KIND_START, TIME_MAX);
        send_event(KIND_NAV_END, 63'd0);
        send_event(KIND_START, 63'd0);
        send_event(KIND_NAV_END, TIME_MAX);
        wait_for_results();
        write_config(48'd0, {40'hFF_FFFF_FFFF, 8'd0});
        send_event(KIND_START, TIME_MAX);
        send_event(KIND_NAV_END, TIME_MAX);
        send_event(KIND_START, 63'd0);
        send_event(KIND_REQ_START, 63'd0);
        send_event(KIND_REQ_END, 63'd0);
        send_event(KIND_NAV_END, 63'd1);
        wait_for_results();
    endtask

    // Hold off the result side long enough to back the block up into its input.
    task automatic check_stall_recovery();
        logic [FIELD_TIME_W-1:0] stamp;
        write_config(48'd20, 48'd1);
        src_gap_max = 0;
        sink_gap_max = 0;
        sink_hold = 300;
        stamp = 63'd500;
        send_event(KIND_START, stamp);
        repeat (40)
        begin
            stamp = stamp + 63'($urandom_range(0, 8));
            send_event($urandom_range(0, 1) ? KIND_REQ_START : KIND_REQ_END, stamp);
        end
        wait_for_results();
    endtask

    // Climb the request counter well past the tolerance, then walk it back down to it.
    task automatic check_request_counter();
        write_config(48'd10, 48'd3);
        src_gap_max = 0;
        sink_gap_max = 0;
        send_event(KIND_START, 63'd0);
        repeat (20) send_event(KIND_REQ_START, 63'd0);
        repeat (17) send_event(KIND_REQ_END, 63'd5);
        send_event(KIND_NAV_END, 63'd16);
        wait_for_results();
    endtask

    function automatic int unsigned pick_gap_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 15;
        endcase
    endfunction

    task automatic run_trace();
        logic [63:0] word;
        logic [63:0] span;
        logic [FIELD_TIME_W-1:0] stamp;
        logic [KIND_W-1:0] kind_sel;
        int unsigned roll;
        word = rand_word();
        stamp = ($urandom_range(0, 1) != 0) ? word[FIELD_TIME_W-1:0]
                                            : 63'($urandom_range(0, 100000));
        span = {16'd0, win_len};
        // drop the opening start now and then
        if ($urandom_range(0, 9) != 0)
            send_event(KIND_START, stamp);
        repeat ($urandom_range(4, 30))
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                stamp = stamp + 63'(rand_word() % (span / 3 + 1));
            else if (roll < 97 && roll >= 80)
                stamp = stamp + 63'(span) + 63'($urandom_range(0, 2));
            else if (roll >= 97)
                stamp = stamp - 63'($urandom_range(1, 1000));
            roll = $urandom_range(0, 99);
            if (roll < 18)
                kind_sel = KIND_TASK_START;
            else if (roll < 40)
                kind_sel = KIND_TASK_END;
            else if (roll < 60)
                kind_sel = KIND_REQ_START;
            else if (roll < 80)
                kind_sel = KIND_REQ_END;
            else if (roll < 92)
                kind_sel = KIND_NAV_END;
            else if (roll < 96)
                kind_sel = $urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6;
            else
                kind_sel = KIND_START;
            send_event(kind_sel, stamp);
        end
    endtask

    task automatic check_random_traces();
        int unsigned goal;
        int unsigned phase;
        logic [63:0] word;
        logic [WINDOW_W-1:0] length;
        logic [TOL_W-1:0] tol;
        goal = sent_items + RANDOM_ITEMS;
        phase = 0;
        while (sent_items < goal)
        begin
            word = rand_word();
            case (phase % 6)
                0:
                begin
                    length = 48'($urandom_range(0, 200));
                    tol = 8'($urandom_range(0, 3));
                end
                1:
                begin
                    length = '0;
                    tol = '0;
                end
                2:
                begin
                    length = word[WINDOW_W-1:0];
                    tol = word[63:56];
                end
                3:
                begin
                    length = '1;
                    tol = '1;
                end
                4:
                begin
                    length = WINDOW_RESET;
                    tol = TOL_RESET;
                end
                default:
                begin
                    length = 48'($urandom_range(1, 5000));
                    tol = 8'($urandom_range(0, 2));
                end
            endcase
            wait_for_results();
            write_config(length, {word[39:0], tol});
            src_gap_max = pick_gap_max();
            sink_gap_max = pick_gap_max();
            repeat ($urandom_range(4, 7)) run_trace();
            phase++;
        end
    endtask

    initial
    begin : result_sink
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold != 0)
            begin
                gap = sink_hold;
                sink_hold = 0;
            end
            else
                gap = $urandom_range(sink_gap_max, 0);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with none outstanding: reached %0b time %0d",
                             $time, out_data.reached, out_data.interactive_time);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_data.reached !== want.reached
                    || out_data.interactive_time !== want.interactive_time)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: reached exp %0b got %0b, time exp %0d got %0d",
                                 $time, want.reached, out_data.reached,
                                 want.interactive_time, out_data.interactive_time);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reset_defaults();
        check_event_kinds();
        check_field_extremes();
        check_stall_recovery();
        check_request_counter();
        check_random_traces();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
